// ===== design/tcgw_pkg.sv =====
// Shared types and constants for the text console grid writer.
// Holds the command beat format passed from front to back through the queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcgw_pkg;

  // Operation codes on the input channel
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Character codes with special meaning
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Command queue geometry (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_CR,
    CMD_LF,
    CMD_PUT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [5:0] read_col;
    logic       read_ok;
  } cmd_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic clearing;
  } bck_status_t;

endpackage

`default_nettype wire

// ===== design/text_console_grid_writer_core.sv =====
// Top level of the text console grid writer: front end, command queue, back end.
// Depends on tcgw_pkg, tcgw_front, tcgw_queue, tcgw_back.
//
//   Channel | Direction | Handshake            | Beat contents
//   --------+-----------+----------------------+-------------------------------------------
//   in_     | input     | in_valid / in_ready  | opcode, char_code, read_row, read_col
//   out_    | output    | out_valid/out_ready  | cell_char, cursor_col, cursor_row, scrolled
//
// Sequencing: CR, LF, printable put without scroll and out-of-range read end in S_IDLE;
//   an in-range read goes on to S_RDATA (registered memory read). A scrolling put goes
//   via S_BLANK and S_WRITE: the screen memory's single write port blanks the recycled row.
// Reset: synchronous, active low; afterwards a clearing pass writes spaces to all
//   ROWS*COLUMNS cells with in_ready held low.
// Stalls: a two-beat command queue lets input continue while the back end works; the
//   result register holds a beat until out_ready, and the back end waits for it.
`timescale 1ns / 1ps
`default_nettype none

module text_console_grid_writer_core #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 24
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_opcode,
  input  wire  [7:0] in_char_code,
  input  wire  [4:0] in_read_row,
  input  wire  [5:0] in_read_col,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_cell_char,
  output logic [5:0] out_cursor_col,
  output logic [4:0] out_cursor_row,
  output logic       out_scrolled
);

  // Front to queue
  logic                  q_push;
  tcgw_pkg::cmd_t        q_wdata;
  logic                  q_full;
  // Queue to back
  logic                  q_pop;
  tcgw_pkg::cmd_t        q_rdata;
  logic                  q_empty;
  // Back end status (clearing pass in progress)
  tcgw_pkg::bck_status_t status;

  // Front end: classifies each beat as read, CR, LF or printable put, and
  // range-checks the read address up front.
  tcgw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .status       (status),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  tcgw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: screen memory addressed through a circular top-row pointer, so
  // a scroll moves the pointer and only blanks one row.
  tcgw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_char  (out_cell_char),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_scrolled   (out_scrolled)
  );

endmodule

`default_nettype wire

// ===== design/tcgw_front.sv =====
// Front end: accepts input beats, classifies them into commands.
// Depends on tcgw_pkg; feeds tcgw_queue.
`timescale 1ns / 1ps
`default_nettype none

module tcgw_front #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 24
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_opcode,
  input  wire  [7:0]           in_char_code,
  input  wire  [4:0]           in_read_row,
  input  wire  [5:0]           in_read_col,
  input  tcgw_pkg::bck_status_t status,
  input  wire                  q_full,
  output logic                 q_push,
  output tcgw_pkg::cmd_t       q_wdata
);

  localparam logic [6:0] ROWS_W = 7'(ROWS);
  localparam logic [8:0] COLS_W = 9'(COLUMNS);

  // Hold input off while the screen is being cleared after reset
  logic hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b1;
    end else begin
      hold_r <= status.clearing;
    end
  end

  assign in_ready = !q_full && !hold_r && !status.clearing;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_wdata           = '0;
    q_wdata.char_code = in_char_code;
    q_wdata.read_row  = in_read_row;
    q_wdata.read_col  = in_read_col;
    q_wdata.read_ok   = ({2'b00, in_read_row} < ROWS_W) && ({3'b000, in_read_col} < COLS_W);
    if (in_opcode == tcgw_pkg::OP_READ) begin
      q_wdata.kind = tcgw_pkg::CMD_READ;
    end else if (in_char_code == tcgw_pkg::CHAR_CR) begin
      q_wdata.kind = tcgw_pkg::CMD_CR;
    end else if (in_char_code == tcgw_pkg::CHAR_LF) begin
      q_wdata.kind = tcgw_pkg::CMD_LF;
    end else begin
      q_wdata.kind = tcgw_pkg::CMD_PUT;
    end
  end

endmodule

`default_nettype wire

// ===== design/tcgw_queue.sv =====
// Short command queue between front and back end.
// Depends on tcgw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcgw_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  tcgw_pkg::cmd_t wdata,
  output logic           full,
  input  wire            pop,
  output tcgw_pkg::cmd_t rdata,
  output logic           empty
);

  tcgw_pkg::cmd_t                    ent_r [tcgw_pkg::QUEUE_DEPTH];
  logic [tcgw_pkg::QUEUE_AW-1:0]     wr_ptr_r;
  logic [tcgw_pkg::QUEUE_AW-1:0]     rd_ptr_r;
  logic [tcgw_pkg::QUEUE_CW-1:0]     cnt_r;

  assign full  = (cnt_r == tcgw_pkg::QUEUE_CW'(tcgw_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tcgw_back.sv =====
// Back end: screen memory with circular row base, cursor, scroll and result register.
// Depends on tcgw_pkg; drains tcgw_queue.
`timescale 1ns / 1ps
`default_nettype none

module tcgw_back #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 24
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_empty,
  input  tcgw_pkg::cmd_t        q_rdata,
  output logic                  q_pop,
  output tcgw_pkg::bck_status_t status,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            out_cell_char,
  output logic [5:0]            out_cursor_col,
  output logic [4:0]            out_cursor_row,
  output logic                  out_scrolled
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = $clog2(ROWS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int SW    = PW + 1;
  localparam int AW    = PW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);

  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [PW-1:0] PROW_LAST = PW'(ROWS - 1);
  localparam logic [RW-1:0] ROW_PAST = RW'(ROWS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [SW-1:0] ROWS_S   = SW'(ROWS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_BLANK = 5'b00100,
    S_WRITE = 5'b01000,
    S_RDATA = 5'b10000
  } bck_state_t;

  bck_state_t     state_r, state_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [PW-1:0]  top_r, top_nxt;
  logic [CW-1:0]  clr_col_r, clr_col_nxt;
  logic [PW-1:0]  clr_row_r, clr_row_nxt;
  logic [7:0]     pend_r, pend_nxt;
  logic [7:0]     rd_data_r;
  logic [7:0]     mem_r [0:DEPTH-1];

  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_wa, mem_ra;
  logic [7:0]     mem_wd;

  logic           out_valid_r;
  logic [7:0]     out_cell_r;
  logic [5:0]     out_col_r;
  logic [4:0]     out_row_r;
  logic           out_scr_r;
  logic           out_free, out_load, ld_cell, ld_scr;

  logic [CW-1:0]  put_col;
  logic [RW-1:0]  put_row;

  // Logical row to physical row, given the current top-of-screen row
  function automatic logic [PW-1:0] phys_row(input logic [SW-1:0] lrow,
                                             input logic [PW-1:0] top);
    logic [SW-1:0] s;
    s = {1'b0, top} + lrow;
    if (s >= ROWS_S) begin
      s = s - ROWS_S;
    end
    return PW'(s);
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign status.clearing = (state_r == S_CLEAR);

  // Cursor after a printable put
  always_comb begin
    if (col_r == COL_LAST) begin
      put_col = '0;
      put_row = (row_r < ROW_PAST) ? row_r + 1'b1 : row_r;
    end else begin
      put_col = col_r + 1'b1;
      put_row = row_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    top_nxt     = top_r;
    clr_col_nxt = clr_col_r;
    clr_row_nxt = clr_row_r;
    pend_nxt    = pend_r;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = tcgw_pkg::CHAR_SPACE;
    mem_re      = 1'b0;
    mem_ra      = '0;
    out_load    = 1'b0;
    ld_cell     = 1'b0;
    ld_scr      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = {clr_row_r, clr_col_r};
        if (clr_col_r == COL_LAST) begin
          clr_col_nxt = '0;
          if (clr_row_r == PROW_LAST) begin
            clr_row_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            clr_row_nxt = clr_row_r + 1'b1;
          end
        end else begin
          clr_col_nxt = clr_col_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          unique case (q_rdata.kind)
            tcgw_pkg::CMD_READ: begin
              if (q_rdata.read_ok) begin
                mem_re    = 1'b1;
                mem_ra    = {phys_row(SW'(q_rdata.read_row), top_r), CW'(q_rdata.read_col)};
                state_nxt = S_RDATA;
              end else begin
                out_load = 1'b1;
              end
            end
            tcgw_pkg::CMD_CR: begin
              col_nxt  = '0;
              row_nxt  = (row_r < ROW_PAST) ? row_r + 1'b1 : row_r;
              out_load = 1'b1;
            end
            tcgw_pkg::CMD_LF: begin
              out_load = 1'b1;
            end
            tcgw_pkg::CMD_PUT: begin
              if (row_r == ROW_PAST) begin
                // Scroll: old top row becomes the bottom, blank it first
                pend_nxt    = q_rdata.char_code;
                top_nxt     = (top_r == PROW_LAST) ? '0 : top_r + 1'b1;
                clr_row_nxt = top_r;
                clr_col_nxt = '0;
                row_nxt     = ROW_LAST;
                state_nxt   = S_BLANK;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = {phys_row(SW'(row_r), top_r), col_r};
                mem_wd   = q_rdata.char_code;
                col_nxt  = put_col;
                row_nxt  = put_row;
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_BLANK: begin
        mem_we = 1'b1;
        mem_wa = {clr_row_r, clr_col_r};
        if (clr_col_r == COL_LAST) begin
          clr_col_nxt = '0;
          state_nxt   = S_WRITE;
        end else begin
          clr_col_nxt = clr_col_r + 1'b1;
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wa    = {phys_row(SW'(row_r), top_r), col_r};
        mem_wd    = pend_r;
        col_nxt   = put_col;
        row_nxt   = put_row;
        out_load  = 1'b1;
        ld_scr    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RDATA: begin
        out_load  = 1'b1;
        ld_cell   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Screen memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      col_r       <= '0;
      row_r       <= '0;
      top_r       <= '0;
      clr_col_r   <= '0;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      top_r       <= top_nxt;
      clr_col_r   <= clr_col_nxt;
      clr_row_r   <= clr_row_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (out_load) begin
      out_cell_r <= ld_cell ? rd_data_r : 8'd0;
      out_col_r  <= 6'(col_nxt);
      out_row_r  <= 5'(row_nxt);
      out_scr_r  <= ld_scr;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_cell_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_scrolled   = out_scr_r;

endmodule

`default_nettype wire

// ===== design/tcgw_checker.sv =====
// Port-level checks for the text console grid writer, bound to the top level.
// Depends on text_console_grid_writer_core.
`timescale 1ns / 1ps
`default_nettype none

module tcgw_checker #(
  parameter int ROWS = 24
) (
  input wire       clk,
  input wire       rst_n,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_cell_char,
  input wire [5:0] out_cursor_col,
  input wire [4:0] out_cursor_row,
  input wire       out_scrolled
);

  localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);
  localparam logic [4:0] ROW_PAST = 5'(ROWS);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_char)
      && $stable(out_cursor_col) && $stable(out_cursor_row) && $stable(out_scrolled))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending and holds input off for the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("channel active straight after reset");

  // A scroll leaves the cursor on the last line, or just past it after a wrap
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |->
      (out_cursor_row == ROW_LAST) || (out_cursor_row == ROW_PAST && out_cursor_col == 6'd0))
    else $error("cursor row wrong after scroll");

  // Only reads return a cell, and reads never scroll
  a_read_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cell_char != 8'd0) |-> !out_scrolled)
    else $error("beat carries both cell data and a scroll");

endmodule

bind text_console_grid_writer_core tcgw_checker #(
  .ROWS (ROWS)
) u_tcgw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cell_char  (out_cell_char),
  .out_cursor_col (out_cursor_col),
  .out_cursor_row (out_cursor_row),
  .out_scrolled   (out_scrolled)
);

`default_nettype wire

// ===== bench/tb_text_console_grid_writer_core.sv =====
// Self-checking bench for text_console_grid_writer_core: directed and random put/read beats.
// Holds its own copy of the screen and cursor and checks every result beat in order.
// Depends on tcgw_pkg and the core itself.
`timescale 1ns / 1ps

module tb_text_console_grid_writer_core;

  localparam int SCREEN_COLS  = 64;
  localparam int SCREEN_ROWS  = 24;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int RANDOM_BEATS = 650;
  // Worst case is a scroll per put with long receiver stalls, plus the clearing pass.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [5:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
  } console_result_t;

  // Shadow console: applies each accepted command to its own screen copy and
  // queues the result beat the core must return for it.
  class console_scoreboard;
    logic [7:0]      screen[SCREEN_CELLS];
    int unsigned     col;
    int unsigned     row;
    console_result_t expected_results[$];
    int unsigned     errors;

    function new();
      foreach (screen[i]) screen[i] = tcgw_pkg::CHAR_SPACE;
      col    = 0;
      row    = 0;
      errors = 0;
    endfunction

    function void next_line();
      if (row < SCREEN_ROWS) row++;
    endfunction

    function void note_command(logic op, logic [7:0] ch, logic [4:0] rrow,
                               logic [5:0] rcol);
      console_result_t res;
      res = '0;
      if (op == tcgw_pkg::OP_READ) begin
        if (rrow < SCREEN_ROWS && rcol < SCREEN_COLS)
          res.cell_char = screen[rrow * SCREEN_COLS + rcol];
      end else if (ch == tcgw_pkg::CHAR_CR) begin
        col = 0;
        next_line();
      end else if (ch != tcgw_pkg::CHAR_LF) begin
        // Past the last line: shift everything up one row, blank the bottom one
        if (row >= SCREEN_ROWS) begin
          for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
            screen[i] = screen[i + SCREEN_COLS];
          for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
            screen[i] = tcgw_pkg::CHAR_SPACE;
          row = SCREEN_ROWS - 1;
          res.scrolled = 1'b1;
        end
        screen[row * SCREEN_COLS + col] = ch;
        col++;
        if (col >= SCREEN_COLS) begin
          col = 0;
          next_line();
        end
      end
      res.cursor_col = col[5:0];
      res.cursor_row = row[4:0];
      expected_results.push_back(res);
    endfunction

    function void check_result(console_result_t got);
      console_result_t exp;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.cell_char !== exp.cell_char) begin
        $error("cell_char: expected %0d, got %0d", exp.cell_char, got.cell_char);
        errors++;
      end
      if (got.cursor_col !== exp.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", exp.cursor_col, got.cursor_col);
        errors++;
      end
      if (got.cursor_row !== exp.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", exp.cursor_row, got.cursor_row);
        errors++;
      end
      if (got.scrolled !== exp.scrolled) begin
        $error("scrolled: expected %0d, got %0d", exp.scrolled, got.scrolled);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_opcode    = tcgw_pkg::OP_PUT;
  logic [7:0] in_char_code = '0;
  logic [4:0] in_read_row  = '0;
  logic [5:0] in_read_col  = '0;
  logic       out_ready    = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_cell_char;
  logic [5:0] out_cursor_col;
  logic [4:0] out_cursor_row;
  logic       out_scrolled;

  console_scoreboard sb = new();

  // Idle rates in percent of cycles, changed between the three phases
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 77;
  int unsigned beats_counted = 0;
  int unsigned cycles        = 0;

  text_console_grid_writer_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_char (out_cell_char),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_scrolled  (out_scrolled)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_text_console_grid_writer_core NOT OK");
      $finish;
    end
  end

  // Everything driven at posedge is settled by the falling edge, so both
  // handshakes are judged here and take effect at the next rising edge.
  // Input first: a beat's result can never appear in the same cycle.
  always @(negedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_command(in_opcode, in_char_code, in_read_row, in_read_col);
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_cell_char, out_cursor_col, out_cursor_row, out_scrolled});
  end

  // Offers one beat and returns at the rising edge that takes it.
  // A random gap with valid low comes first, at the sender's idle rate.
  task automatic send_beat(input logic op, input logic [7:0] ch,
                           input logic [4:0] rrow, input logic [5:0] rcol);
    bit accepted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_char_code <= ch;
    in_read_row  <= rrow;
    in_read_col  <= rcol;
    do begin
      @(negedge clk);
      accepted = in_ready;
      @(posedge clk);
    end while (!accepted);
    // A line feed changes nothing, so it does not count as real work
    if (!(op == tcgw_pkg::OP_PUT && ch == tcgw_pkg::CHAR_LF)) beats_counted++;
    // Idle mix follows progress through the random part
    if (beats_counted > 2 * RANDOM_BEATS / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (beats_counted > RANDOM_BEATS / 3) begin
      send_idle_pct = 77;
      recv_idle_pct = 26;
    end
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_beat(tcgw_pkg::OP_PUT, ch, 5'($urandom_range(31)), 6'($urandom_range(63)));
  endtask

  task automatic read_cell(input logic [4:0] rrow, input logic [5:0] rcol);
    send_beat(tcgw_pkg::OP_READ, 8'($urandom_range(255)), rrow, rcol);
  endtask

  // Mostly printable text, now and then any byte at all (CR and LF included)
  function automatic logic [7:0] text_byte();
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h7e, 8'h20));
  endfunction

  initial begin
    int unsigned seg;
    int unsigned len;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corners, out-of-range reads, extreme bytes, CR and LF
    read_cell(5'd0, 6'd0);
    read_cell(5'd23, 6'd63);
    read_cell(5'd31, 6'd0);
    read_cell(5'd24, 6'd63);
    put_char(tcgw_pkg::CHAR_LF);
    put_char(8'h00);
    put_char(8'hff);
    put_char(8'h41);
    put_char(tcgw_pkg::CHAR_CR);
    put_char(8'h7e);
    put_char(tcgw_pkg::CHAR_LF);
    read_cell(5'd0, 6'd0);
    read_cell(5'd0, 6'd1);
    read_cell(5'd0, 6'd3);
    read_cell(5'd1, 6'd0);
    read_cell(5'd1, 6'd1);
    beats_counted = 0;

    // Random: whole lines of text dominate so the cursor walks down to the
    // bottom, wraps there and keeps scrolling; CR runs push the row against
    // its ceiling; reads and stray line feeds are sprinkled in between.
    while (beats_counted < RANDOM_BEATS) begin
      seg = $urandom_range(99);
      if (seg < 55) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(70, 60) : $urandom_range(40);
        repeat (len) put_char(text_byte());
        if ($urandom_range(4) != 0) put_char(tcgw_pkg::CHAR_CR);
      end else if (seg < 65) begin
        repeat ($urandom_range(30, 1)) put_char(tcgw_pkg::CHAR_CR);
      end else if (seg < 92) begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(4) == 0)
            read_cell(5'($urandom_range(31, 24)), 6'($urandom_range(63)));
          else
            read_cell(5'($urandom_range(23)), 6'($urandom_range(63)));
        end
      end else begin
        put_char(tcgw_pkg::CHAR_LF);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_text_console_grid_writer_core OK");
    end else begin
      $display("tb_text_console_grid_writer_core NOT OK");
    end
    $finish;
  end

endmodule
